// ----- hdl/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and constants shared by the I2C master bit sequencer modules.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int unsigned ByteBits    = 8;
  localparam int unsigned BitIdxW     = 4;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [7:0] DelayTicksRst = 8'd10;
  localparam logic [7:0] AckTimeoutRst = 8'd250;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDelayTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAckTimeout = 2'd1;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_WAIT  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_S_A    = 5'd1,
    PH_S_B    = 5'd2,
    PH_S_C    = 5'd3,
    PH_P_A    = 5'd4,
    PH_P_B    = 5'd5,
    PH_FIN    = 5'd6,
    PH_W_DATA = 5'd7,
    PH_W_HIGH = 5'd8,
    PH_W_LOW  = 5'd9,
    PH_A_REL  = 5'd10,
    PH_A_HIGH = 5'd11,
    PH_A_POLL = 5'd12,
    PH_R_LOW  = 5'd13,
    PH_R_HIGH = 5'd14,
    PH_K_LOW  = 5'd15,
    PH_K_HIGH = 5'd16,
    PH_K_END  = 5'd17
  } phase_e;

  typedef struct packed {
    logic [7:0] delay_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic [2:0]         active_cmd;
    logic [7:0]         delay_cnt;
    logic [BitIdxW-1:0] bit_idx;
    logic [7:0]         shift_reg;
    logic [7:0]         poll_cnt;
    logic               ack_choice;
    logic               scl;
    logic               sda;
    logic               fail;
    logic [7:0]         rx_hold;
  } seq_state_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_data;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

endpackage

// ----- hdl/i2cms_step.sv -----
// ----------------------------------------------------------------------------
// i2cms_step
// Next-state logic of the bit sequencer for one tick: command launch,
// delay countdown and the per-phase bus line updates.
// ----------------------------------------------------------------------------
module i2cms_step
  import i2cms_pkg::*;
(
  input  seq_state_t st_i,
  input  tick_t      tick_i,
  input  cfg_t       cfg_i,
  output seq_state_t st_o,
  output logic       done_o
);

  logic [7:0]         reload;
  logic [BitIdxW-1:0] bit_inc;
  seq_state_t         s;
  logic               done;

  // Delay phase length, zero acts as one tick
  assign reload  = (cfg_i.delay_ticks == 8'd0) ? 8'd1 : cfg_i.delay_ticks;
  assign bit_inc = st_i.bit_idx + BitIdxW'(1);

  always_comb begin
    s    = st_i;
    done = 1'b0;

    // Launch a new command when idle
    if (s.phase == PH_IDLE && tick_i.cmd_valid && tick_i.mode <= CMD_READ) begin
      s.active_cmd = tick_i.mode;
      case (tick_i.mode)
        CMD_START: s.phase = PH_S_A;
        CMD_STOP:  s.phase = PH_P_A;
        CMD_WRITE: s.phase = PH_W_DATA;
        CMD_WAIT:  s.phase = PH_A_REL;
        default:   s.phase = PH_R_LOW;
      endcase
      s.delay_cnt  = 8'd0;
      s.bit_idx    = '0;
      s.poll_cnt   = 8'd0;
      s.fail       = 1'b0;
      s.shift_reg  = (tick_i.mode == CMD_WRITE) ? tick_i.tx_data : 8'd0;
      s.ack_choice = tick_i.send_ack;
    end

    // Count down the delay, else step the phase
    if (s.phase != PH_IDLE) begin
      if (s.delay_cnt != 8'd0) begin
        s.delay_cnt = s.delay_cnt - 8'd1;
      end else begin
        case (s.phase)
          PH_S_A: begin
            s.scl = 1'b1; s.sda = 1'b1;
            s.phase = PH_S_B; s.delay_cnt = reload;
          end
          PH_S_B: begin
            s.sda = 1'b0;
            s.phase = PH_S_C; s.delay_cnt = reload;
          end
          PH_S_C: begin
            s.scl = 1'b0;
            done = 1'b1;
          end
          PH_P_A: begin
            s.scl = 1'b0; s.sda = 1'b0;
            s.phase = PH_P_B; s.delay_cnt = reload;
          end
          PH_P_B: begin
            s.scl = 1'b1; s.sda = 1'b1;
            s.phase = PH_FIN; s.delay_cnt = reload;
          end
          PH_FIN: done = 1'b1;
          PH_W_DATA: begin
            s.scl = 1'b0; s.sda = s.shift_reg[ByteBits-1];
            s.shift_reg = {s.shift_reg[ByteBits-2:0], 1'b0};
            s.phase = PH_W_HIGH; s.delay_cnt = reload;
          end
          PH_W_HIGH: begin
            s.scl = 1'b1;
            s.phase = PH_W_LOW; s.delay_cnt = reload;
          end
          PH_W_LOW: begin
            s.scl = 1'b0;
            s.bit_idx = bit_inc;
            s.phase = (bit_inc < BitIdxW'(ByteBits)) ? PH_W_DATA : PH_FIN;
            s.delay_cnt = reload;
          end
          PH_A_REL: begin
            s.sda = 1'b1;
            s.phase = PH_A_HIGH; s.delay_cnt = reload;
          end
          PH_A_HIGH: begin
            s.scl = 1'b1;
            s.phase = PH_A_POLL; s.delay_cnt = reload;
          end
          PH_A_POLL: begin
            // Poll the acknowledge, give up into a stop on timeout
            if (!tick_i.sda_in) begin
              s.scl = 1'b0;
              done = 1'b1;
            end else if (s.poll_cnt >= cfg_i.ack_timeout) begin
              s.fail  = 1'b1;
              s.phase = PH_P_A;
            end else begin
              s.poll_cnt = s.poll_cnt + 8'd1;
            end
          end
          PH_R_LOW: begin
            s.scl = 1'b0; s.sda = 1'b1;
            s.phase = PH_R_HIGH; s.delay_cnt = reload;
          end
          PH_R_HIGH: begin
            s.scl = 1'b1;
            s.shift_reg = {s.shift_reg[ByteBits-2:0], tick_i.sda_in};
            s.bit_idx = bit_inc;
            s.phase = (bit_inc < BitIdxW'(ByteBits)) ? PH_R_LOW : PH_K_LOW;
            s.delay_cnt = reload;
          end
          PH_K_LOW: begin
            s.scl = 1'b0; s.sda = ~s.ack_choice;
            s.rx_hold = s.shift_reg;
            s.phase = PH_K_HIGH; s.delay_cnt = reload;
          end
          PH_K_HIGH: begin
            s.scl = 1'b1;
            s.phase = PH_K_END; s.delay_cnt = reload;
          end
          PH_K_END: begin
            s.scl = 1'b0;
            done = 1'b1;
          end
          default: s.phase = PH_IDLE;
        endcase
        if (done) begin
          s.phase     = PH_IDLE;
          s.delay_cnt = 8'd0;
        end
      end
    end

    st_o   = s;
    done_o = done;
  end

endmodule

// ----- hdl/i2c_master_bit_sequencer_core.sv -----
// An accepted tick's result is registered in the output register.
// Throughput: one tick per cycle unless a stalled full output register holds off
// requests; the step logic between state and output register sets that figure.
// Reset: asynchronous, active low; sequencer idle, SCL and SDA released,
// delay_ticks 10, ack_timeout 250, output register empty.
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// I2C master bit sequencer: one request per bus timing tick, one result per
// request carrying the driven line levels and the command status.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core
  import i2cms_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  // Request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_valid_i,
  input  logic [2:0]         mode_i,
  input  logic [7:0]         tx_data_i,
  input  logic               send_ack_i,
  input  logic               sda_in_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               scl_level_o,
  output logic               sda_level_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic [7:0]         rx_byte_o,
  output logic               ack_failed_o
);

  cfg_t       cfg_q;
  seq_state_t st_q, st_d;
  tick_t      tick;
  logic       done;
  logic       accept;
  logic       out_valid_q;
  logic       scl_q, sda_q, busy_q, done_q, fail_q;
  logic [7:0] rx_q;

  assign cfg_ready_o = 1'b1;

  // Accept a request while the output register is free or being drained
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign tick = '{cmd_valid: cmd_valid_i, mode: mode_i, tx_data: tx_data_i,
                  send_ack: send_ack_i, sda_in: sda_in_i};

  i2cms_step u_step (
    .st_i   (st_q),
    .tick_i (tick),
    .cfg_i  (cfg_q),
    .st_o   (st_d),
    .done_o (done)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_ticks <= DelayTicksRst;
      cfg_q.ack_timeout <= AckTimeoutRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDelayTicks: cfg_q.delay_ticks <= cfg_data_i;
        RegAckTimeout: cfg_q.ack_timeout <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state, advance on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, active_cmd: 3'd0, delay_cnt: 8'd0, bit_idx: '0,
                shift_reg: 8'd0, poll_cnt: 8'd0, ack_choice: 1'b0, scl: 1'b1,
                sda: 1'b1, fail: 1'b0, rx_hold: 8'd0};
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  // Output register valid: set on accept, drop when drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload, hold while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      scl_q  <= st_d.scl;
      sda_q  <= st_d.sda;
      busy_q <= (st_d.phase != PH_IDLE);
      done_q <= done;
      rx_q   <= st_d.rx_hold;
      fail_q <= st_d.fail;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_level_o  = scl_q;
  assign sda_level_o  = sda_q;
  assign busy_res_o   = busy_q;
  assign done_res_o   = done_q;
  assign rx_byte_o    = rx_q;
  assign ack_failed_o = fail_q;

endmodule

// ----- test/i2c_bit_seq_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_bit_seq_checker
// Watches the request, result and register write channels of the I2C master
// bit sequencer. Keeps its own model of the sequencer and of both registers,
// predicts the line levels and status for each accepted request, and compares
// every accepted result against the oldest prediction. Mismatches are counted
// and handed to the testbench top.
// ----------------------------------------------------------------------------
module i2c_bit_seq_checker
  import i2cms_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Register write channel
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  // Request channel
  input  logic               req_valid_i,
  input  logic               req_stall_i,
  input  logic               cmd_valid_i,
  input  logic [2:0]         mode_i,
  input  logic [7:0]         tx_data_i,
  input  logic               send_ack_i,
  input  logic               sda_in_i,
  // Result channel
  input  logic               res_valid_i,
  input  logic               res_stall_i,
  input  logic               scl_i,
  input  logic               sda_i,
  input  logic               busy_i,
  input  logic               done_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               ack_failed_i,
  // Status toward the top
  output int                 errors_o,
  output int                 pending_o,
  output logic               idle_next_o
);

  typedef struct packed {
    phase_e     phase;
    logic [7:0] wait_cnt;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [7:0] polls;
    logic       ack_bit;
    logic       scl;
    logic       sda;
    logic       failed;
    logic [7:0] rx_byte;
  } seq_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       failed;
  } tick_res_t;

  seq_t       seq;
  logic [7:0] dly_ticks;
  logic [7:0] ack_limit;
  tick_res_t  tick_res_q[$];

  // Advance the sequencer by one bus tick and return the lines it drives
  function automatic seq_t seq_step(input seq_t s, input logic cv, input logic [2:0] md,
                                    input logic [7:0] txd, input logic sack,
                                    input logic sda_smp, input logic [7:0] dly,
                                    input logic [7:0] lim, output tick_res_t r);
    seq_t       n;
    phase_e     nxt;
    logic       fin;
    logic       arm;
    logic [7:0] reload;
    n      = s;
    fin    = 1'b0;
    arm    = 1'b1;
    reload = (dly == 8'd0) ? 8'd1 : dly;

    // Take a new command only while idle; unknown modes are dropped
    if (n.phase == PH_IDLE && cv && md <= CMD_READ) begin
      n.wait_cnt = '0;
      n.bit_cnt  = '0;
      n.polls    = '0;
      n.failed   = 1'b0;
      n.shreg    = (md == CMD_WRITE) ? txd : 8'h00;
      n.ack_bit  = sack;
      case (md)
        CMD_START: n.phase = PH_S_A;
        CMD_STOP:  n.phase = PH_P_A;
        CMD_WRITE: n.phase = PH_W_DATA;
        CMD_WAIT:  n.phase = PH_A_REL;
        default:   n.phase = PH_R_LOW;
      endcase
    end

    nxt = n.phase;
    if (n.phase != PH_IDLE) begin
      if (n.wait_cnt != 8'd0) begin
        n.wait_cnt = n.wait_cnt - 8'd1;
      end else begin
        case (n.phase)
          PH_S_A: begin
            n.scl = 1'b1;
            n.sda = 1'b1;
            nxt   = PH_S_B;
          end
          PH_S_B: begin
            n.sda = 1'b0;
            nxt   = PH_S_C;
          end
          PH_S_C: begin
            n.scl = 1'b0;
            fin   = 1'b1;
          end
          PH_P_A: begin
            n.scl = 1'b0;
            n.sda = 1'b0;
            nxt   = PH_P_B;
          end
          PH_P_B: begin
            n.scl = 1'b1;
            n.sda = 1'b1;
            nxt   = PH_FIN;
          end
          PH_FIN: fin = 1'b1;
          PH_W_DATA: begin
            n.scl   = 1'b0;
            n.sda   = n.shreg[7];
            n.shreg = {n.shreg[6:0], 1'b0};
            nxt     = PH_W_HIGH;
          end
          PH_W_HIGH: begin
            n.scl = 1'b1;
            nxt   = PH_W_LOW;
          end
          PH_W_LOW: begin
            n.scl     = 1'b0;
            n.bit_cnt = n.bit_cnt + 4'd1;
            nxt       = (n.bit_cnt < 4'(ByteBits)) ? PH_W_DATA : PH_FIN;
          end
          PH_A_REL: begin
            n.sda = 1'b1;
            nxt   = PH_A_HIGH;
          end
          PH_A_HIGH: begin
            n.scl = 1'b1;
            nxt   = PH_A_POLL;
          end
          // Poll every tick: low means acknowledged, too many highs fall into a stop
          PH_A_POLL: begin
            arm = 1'b0;
            if (!sda_smp) begin
              n.scl = 1'b0;
              fin   = 1'b1;
            end else if (n.polls >= lim) begin
              n.failed = 1'b1;
              n.phase  = PH_P_A;
            end else begin
              n.polls = n.polls + 8'd1;
            end
          end
          PH_R_LOW: begin
            n.scl = 1'b0;
            n.sda = 1'b1;
            nxt   = PH_R_HIGH;
          end
          PH_R_HIGH: begin
            n.scl     = 1'b1;
            n.shreg   = {n.shreg[6:0], sda_smp};
            n.bit_cnt = n.bit_cnt + 4'd1;
            nxt       = (n.bit_cnt < 4'(ByteBits)) ? PH_R_LOW : PH_K_LOW;
          end
          PH_K_LOW: begin
            n.scl     = 1'b0;
            n.sda     = ~n.ack_bit;
            n.rx_byte = n.shreg;
            nxt       = PH_K_HIGH;
          end
          PH_K_HIGH: begin
            n.scl = 1'b1;
            nxt   = PH_K_END;
          end
          PH_K_END: begin
            n.scl = 1'b0;
            fin   = 1'b1;
          end
          default: begin
            arm     = 1'b0;
            n.phase = PH_IDLE;
          end
        endcase
        if (fin) begin
          n.phase    = PH_IDLE;
          n.wait_cnt = '0;
        end else if (arm) begin
          n.phase    = nxt;
          n.wait_cnt = reload;
        end
      end
    end

    r.scl    = n.scl;
    r.sda    = n.sda;
    r.busy   = (n.phase != PH_IDLE);
    r.done   = fin;
    r.rx     = n.rx_byte;
    r.failed = n.failed;
    return n;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_miss(input string what, input int got, input int want);
    errors_o++;
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // Tell the top whether the sequencer is idle once the offered request is taken
  always_comb begin : peek_next
    seq_t      peek;
    tick_res_t scratch;
    peek = seq_step(seq, cmd_valid_i, mode_i, tx_data_i, send_ack_i, sda_in_i,
                    dly_ticks, ack_limit, scratch);
    idle_next_o = (peek.phase == PH_IDLE);
  end

  // Track register writes, predict each request, compare each result
  always @(posedge clk_i or negedge rst_ni) begin : watch
    tick_res_t want;
    tick_res_t got;
    if (!rst_ni) begin
      seq       <= '{phase: PH_IDLE, scl: 1'b1, sda: 1'b1, default: '0};
      dly_ticks <= DelayTicksRst;
      ack_limit <= AckTimeoutRst;
      pending_o <= 0;
      errors_o  = 0;
      tick_res_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegDelayTicks: dly_ticks <= cfg_data_i;
          RegAckTimeout: ack_limit <= cfg_data_i;
          default: ;
        endcase
      end
      if (req_valid_i && !req_stall_i) begin
        seq <= seq_step(seq, cmd_valid_i, mode_i, tx_data_i, send_ack_i, sda_in_i,
                        dly_ticks, ack_limit, want);
        tick_res_q.push_back(want);
      end
      if (res_valid_i && !res_stall_i) begin
        got = '{scl: scl_i, sda: sda_i, busy: busy_i, done: done_i, rx: rx_byte_i,
                failed: ack_failed_i};
        if (tick_res_q.size() == 0) begin
          report_miss("result with no request pending", 1, 0);
        end else begin
          want = tick_res_q.pop_front();
          if (got.scl !== want.scl)
            report_miss("scl_level", int'(got.scl), int'(want.scl));
          if (got.sda !== want.sda)
            report_miss("sda_level", int'(got.sda), int'(want.sda));
          if (got.busy !== want.busy)
            report_miss("busy_res", int'(got.busy), int'(want.busy));
          if (got.done !== want.done)
            report_miss("done_res", int'(got.done), int'(want.done));
          if (got.rx !== want.rx)
            report_miss("rx_byte", int'(got.rx), int'(want.rx));
          if (got.failed !== want.failed)
            report_miss("ack_failed", int'(got.failed), int'(want.failed));
        end
      end
      pending_o <= tick_res_q.size();
    end
  end

endmodule

// ----- test/tb_i2c_master_bit_sequencer_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_sequencer_core
// Drives bus ticks into the I2C master bit sequencer: a start at the reset
// register values, a directed pass over every command and corner case at a
// short delay, then random command streams under several delay and timeout
// settings, with random gaps on both channels, a long result hold-off and a
// full drain in between.
// The checker beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_sequencer_core;
  import i2cms_pkg::*;

  // Slowest run: under 800 requests, each with up to the longest random gap and
  // result stall, plus one long hold-off and the drains
  localparam int CycleLimit  = 600000;
  localparam int HoldCycles  = 60;
  localparam int DrainCycles = 8;
  localparam int ModeCodes   = 8;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [7:0]         cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               cmd_valid_i = 1'b0;
  logic [2:0]         mode_i      = '0;
  logic [7:0]         tx_data_i   = '0;
  logic               send_ack_i  = 1'b0;
  logic               sda_in_i    = 1'b1;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               scl_level_o;
  logic               sda_level_o;
  logic               busy_res_o;
  logic               done_res_o;
  logic [7:0]         rx_byte_o;
  logic               ack_failed_o;

  int   errors;
  int   pending;
  logic idle_next;
  int   cycles      = 0;
  int   sent_reqs   = 0;
  int   sent_cmds   = 0;
  int   settings    = 1;
  int   sda_low_pct = 50;
  int   hold_seq    = 0;
  bit   src_gaps    = 1'b1;
  bit   sink_gaps   = 1'b1;

  i2c_master_bit_sequencer_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_valid_i  (cmd_valid_i),
    .mode_i       (mode_i),
    .tx_data_i    (tx_data_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .scl_level_o  (scl_level_o),
    .sda_level_o  (sda_level_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .rx_byte_o    (rx_byte_o),
    .ack_failed_o (ack_failed_o)
  );

  i2c_bit_seq_checker bus_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (in_valid_i),
    .req_stall_i  (in_stall_o),
    .cmd_valid_i  (cmd_valid_i),
    .mode_i       (mode_i),
    .tx_data_i    (tx_data_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .res_valid_i  (out_valid_o),
    .res_stall_i  (out_stall_i),
    .scl_i        (scl_level_o),
    .sda_i        (sda_level_o),
    .busy_i       (busy_res_o),
    .done_i       (done_res_o),
    .rx_byte_i    (rx_byte_o),
    .ack_failed_i (ack_failed_o),
    .errors_o     (errors),
    .pending_o    (pending),
    .idle_next_o  (idle_next)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[i2c_master_bit_sequencer_core] ERROR");
      $finish;
    end
  end

  // Mostly no gap, sometimes a few cycles, rarely a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    else if (roll < 95) return $urandom_range(1, 3);
    else return $urandom_range(10, 30);
  endfunction

  // Stall the result channel at random; hold it off for a long stretch on demand
  initial begin : result_sink
    int run;
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 99) < 30) begin
        run = pick_gap();
        if (run > 0) begin
          out_stall_i <= 1'b1;
          repeat (run) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Offer one request and hold it until the block takes it
  task automatic offer_req(input logic cv, input logic [2:0] md, input logic [7:0] txd,
                           input logic sack);
    int gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_valid_i <= cv;
    mode_i      <= md;
    tx_data_i   <= txd;
    send_ack_i  <= sack;
    sda_in_i    <= ($urandom_range(0, 99) >= sda_low_pct);
    do @(posedge clk_i); while (in_stall_o);
    sent_reqs++;
  endtask

  // Drop valid and wait until every request has its result
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Issue one command from idle and clock the bus until it is idle again
  task automatic run_cmd(input logic [2:0] md, input logic [7:0] txd, input logic sack,
                         input int low_pct, input bit poke);
    logic busy;
    logic extra;
    extra       = poke;
    sda_low_pct = low_pct;
    if (md <= CMD_READ) sent_cmds++;
    offer_req(1'b1, md, txd, sack);
    busy = !idle_next;
    while (busy) begin
      offer_req(extra, CMD_STOP, 8'h00, 1'b0);
      extra = 1'b0;
      busy  = !idle_next;
    end
  endtask

  // Random command stream; new commands mostly land on idle ticks
  task automatic run_random(input int n, input int low_pct, input bit pause_mid);
    logic       idle;
    logic       cv;
    logic [2:0] md;
    idle        = 1'b1;
    sda_low_pct = low_pct;
    for (int k = 0; k < n; k++) begin
      if (pause_mid && k == n / 2) drain();
      if (idle && $urandom_range(0, 99) < 85) begin
        cv = 1'b1;
        if ($urandom_range(0, 99) < 6) begin
          md = 3'($urandom_range(CMD_READ + 1, ModeCodes - 1));
        end else begin
          md = 3'($urandom_range(CMD_START, CMD_READ));
        end
        if (md <= CMD_READ) sent_cmds++;
      end else begin
        cv = ($urandom_range(0, 99) < 10);
        md = 3'($urandom_range(0, ModeCodes - 1));
      end
      offer_req(cv, md, 8'($urandom), 1'($urandom_range(0, 1)));
      idle = idle_next;
    end
    // let the running command finish
    while (!idle) begin
      offer_req(1'b0, CMD_START, 8'h00, 1'b0);
      idle = idle_next;
    end
  endtask

  // Write both registers once nothing is in flight
  task automatic load_regs(input logic [7:0] dly, input logic [7:0] lim);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegDelayTicks;
    cfg_data_i  <= dly;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= RegAckTimeout;
    cfg_data_i  <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One start at reset register values, poked while busy
    run_cmd(CMD_START, 8'h00, 1'b0, 50, 1'b1);

    // Directed pass over every command at a short delay and timeout
    load_regs(8'd1, 8'd4);
    run_cmd(CMD_WRITE, 8'hFF, 1'b0, 50, 1'b0);
    run_cmd(CMD_WRITE, 8'h00, 1'b1, 50, 1'b0);
    run_cmd(CMD_WAIT, 8'h00, 1'b0, 100, 1'b0);
    run_cmd(CMD_READ, 8'h00, 1'b1, 100, 1'b0);
    run_cmd(CMD_READ, 8'hFF, 1'b0, 0, 1'b0);
    run_cmd(CMD_WAIT, 8'h00, 1'b0, 0, 1'b0);
    for (int m = CMD_READ + 1; m < ModeCodes; m++) begin
      run_cmd(3'(m), 8'h5A, 1'b1, 50, 1'b0);
    end
    run_cmd(CMD_STOP, 8'h00, 1'b0, 50, 1'b0);

    // Shortest delay and zero timeout
    load_regs(8'd0, 8'd0);
    run_random(100, 30, 1'b0);

    // No idling on either side
    load_regs(8'd1, 8'd3);
    src_gaps  = 1'b0;
    sink_gaps <= 1'b0;
    run_random(110, 25, 1'b0);
    src_gaps  = 1'b1;
    sink_gaps <= 1'b1;

    // Pause the sender halfway until all results are back
    load_regs(8'd2, 8'd1);
    run_random(100, 40, 1'b1);

    // Long result hold-off while requests keep coming
    load_regs(8'($urandom_range(1, 4)), 8'($urandom_range(2, 20)));
    hold_seq <= hold_seq + 1;
    run_random(110, 20, 1'b0);

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    $display("run covered %0d bus ticks carrying %0d commands under %0d register settings",
             sent_reqs, sent_cmds, settings);
    if (errors == 0) begin
      $display("[i2c_master_bit_sequencer_core] OK");
    end else begin
      $display("[i2c_master_bit_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- i2c_master_bit_sequencer_core.f -----
hdl/i2cms_pkg.sv
hdl/i2cms_step.sv
hdl/i2c_master_bit_sequencer_core.sv
test/i2c_bit_seq_checker.sv
test/tb_i2c_master_bit_sequencer_core.sv
